### rtl/pdpc_pkg.sv
// Shared types, constants and layout tables for the PKCS #1 v1.5 digest padding checker.
// No dependencies; every other file of the block refers to this package by scoped names.

package pdpc_pkg;

  // Block and store sizes.
  localparam int unsigned MAX_BLOCK_BYTES  = 1024;
  localparam int unsigned MAX_DIGEST_BYTES = 64;

  // Field and register widths.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned BLKLEN_W = 11;
  localparam int unsigned DIDX_W   = 6;
  localparam int unsigned LEN_W    = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int unsigned POS_W    = $clog2(MAX_BLOCK_BYTES);
  localparam int unsigned DIG_AW   = $clog2(MAX_DIGEST_BYTES);
  localparam int unsigned CFG_IDX_W = 1;

  // Marker 0x01, eight pad bytes and marker 0x00 frame the DigestInfo.
  localparam int unsigned FRAME_BYTES = 10;

  // Fixed bytes of the layout.
  localparam logic [BYTE_W-1:0] MARK_START = 8'h01;
  localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'hff;
  localparam logic [BYTE_W-1:0] MARK_ZERO  = 8'h00;

  // Request commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DIGEST_KIND  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [BLKLEN_W-1:0] BLOCK_LENGTH_RST = 11'd256;

  // Hash selection codes; the fourth code has no layout.
  typedef enum logic [KIND_W-1:0] {
    KIND_SHA1   = 2'd0,
    KIND_SHA256 = 2'd1,
    KIND_SHA512 = 2'd2
  } kind_e;

  // DigestInfo prefixes, first byte at index 0.
  localparam logic [BYTE_W-1:0] INFO_SHA1 [15] = '{
    8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e,
    8'h03, 8'h02, 8'h1a, 8'h05, 8'h00, 8'h04, 8'h14
  };
  localparam logic [BYTE_W-1:0] INFO_SHA256 [19] = '{
    8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
    8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20
  };
  localparam logic [BYTE_W-1:0] INFO_SHA512 [19] = '{
    8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
    8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40
  };

  // One checked byte on its way from the layout decode to the verdict stage.
  typedef struct packed {
    logic              last;      // final byte of the block, a verdict follows
    logic              load;      // digest load, restarts the check
    logic              cmp_en;    // byte takes part in the compare
    logic              use_dig;   // compare against the digest store
    logic              kind_ok;
    logic              len_err;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] exp_byte;  // fixed layout byte
  } chk_t;

  // Access to the digest store.
  typedef struct packed {
    logic              wr;
    logic              rd;
    logic [DIG_AW-1:0] addr;
    logic [BYTE_W-1:0] wdata;
  } mem_req_t;

  function automatic logic kind_valid(input logic [KIND_W-1:0] kind);
    kind_valid = (kind == KIND_SHA1) || (kind == KIND_SHA256) || (kind == KIND_SHA512);
  endfunction

  function automatic logic [4:0] prefix_len(input logic [KIND_W-1:0] kind);
    logic [4:0] res;
    case (kind)
      KIND_SHA1:   res = 5'd15;
      KIND_SHA256: res = 5'd19;
      KIND_SHA512: res = 5'd19;
      default:     res = 5'd0;
    endcase
    prefix_len = res;
  endfunction

  function automatic logic [6:0] digest_len(input logic [KIND_W-1:0] kind);
    logic [6:0] res;
    case (kind)
      KIND_SHA1:   res = 7'd20;
      KIND_SHA256: res = 7'd32;
      KIND_SHA512: res = 7'd64;
      default:     res = 7'd0;
    endcase
    digest_len = res;
  endfunction

  // Prefix byte at offset idx for the selected hash.
  function automatic logic [BYTE_W-1:0] info_byte(input logic [KIND_W-1:0] kind,
                                                 input logic [4:0] idx);
    logic [BYTE_W-1:0] res;
    res = MARK_ZERO;
    case (kind)
      KIND_SHA1:   if (idx < 5'd15) res = INFO_SHA1[idx[3:0]];
      KIND_SHA256: if (idx < 5'd19) res = INFO_SHA256[idx];
      KIND_SHA512: if (idx < 5'd19) res = INFO_SHA512[idx];
      default:     res = MARK_ZERO;
    endcase
    info_byte = res;
  endfunction

endpackage

### rtl/pdpc_if.sv
// Valid/ready channels of the padding checker: request in, verdict out.
// Depends on pdpc_pkg for the field widths.

interface pdpc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [pdpc_pkg::DIDX_W-1:0]   digest_index;
  logic [pdpc_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output cmd, output digest_index, output data_byte,
                  input ready);
  modport sink (input valid, input cmd, input digest_index, input data_byte,
                output ready);
endinterface

interface pdpc_rsp_if;
  logic valid;
  logic ready;
  logic block_ok;
  logic length_error;

  modport source (output valid, output block_ok, output length_error, input ready);
  modport sink (input valid, input block_ok, input length_error, output ready);
endinterface

### rtl/pdpc_digest_store.sv
// Expected digest store: one write or one registered read per cycle.
// Depends on pdpc_pkg for the store depth and the access struct.

module pdpc_digest_store (
  input  logic                        clk_i,
  input  pdpc_pkg::mem_req_t          mem_req_i,
  output logic [pdpc_pkg::BYTE_W-1:0] rdata_o
);

  logic [pdpc_pkg::BYTE_W-1:0] mem_q [pdpc_pkg::MAX_DIGEST_BYTES];
  logic [pdpc_pkg::BYTE_W-1:0] rdata_q;

  // Write port; contents are undefined until loaded.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr) begin
      mem_q[mem_req_i.addr] <= mem_req_i.wdata;
    end
  end

  // Read data is held while the stage behind it stalls.
  always_ff @(posedge clk_i) begin
    if (mem_req_i.rd) begin
      rdata_q <= mem_q[mem_req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pdpc_seq.sv
// Configuration registers, byte position counter and layout decode, with the input stage.
// Depends on pdpc_pkg and on the request channel in pdpc_if.

module pdpc_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pdpc_req_if.sink                      req,
  input  logic                          cfg_we_i,
  input  logic [pdpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdpc_pkg::BLKLEN_W-1:0] cfg_wdata_i,
  input  logic                          adv_i,
  output pdpc_pkg::chk_t                stage_o,
  output logic                          stage_vld_o,
  output pdpc_pkg::mem_req_t            mem_req_o
);

  localparam int unsigned LW = pdpc_pkg::LEN_W;

  logic [pdpc_pkg::KIND_W-1:0]   kind_q;
  logic [pdpc_pkg::BLKLEN_W-1:0] blen_q;
  logic [pdpc_pkg::POS_W-1:0]    pos_q, pos_d;
  logic                          vld_q;
  pdpc_pkg::chk_t                stage_q, stage_d;

  logic          accept;
  logic          kind_ok;
  logic [LW-1:0] eff_len, pref_len, dig_len, min_len;
  logic [LW-1:0] info_base, zero_pos, dig_base, last_pos, pos_x;
  logic [LW-1:0] info_off, dig_off;

  assign req.ready = !vld_q || adv_i;
  assign accept    = req.valid && req.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= pdpc_pkg::KIND_SHA256;
      blen_q <= pdpc_pkg::BLOCK_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pdpc_pkg::CFG_DIGEST_KIND:  kind_q <= cfg_wdata_i[pdpc_pkg::KIND_W-1:0];
        pdpc_pkg::CFG_BLOCK_LENGTH: blen_q <= cfg_wdata_i;
        default:                    blen_q <= blen_q;
      endcase
    end
  end

  // Length clamp and region boundaries; these follow the configuration only.
  always_comb begin
    if (blen_q == '0) begin
      eff_len = LW'(1);
    end else if (LW'(blen_q) > LW'(pdpc_pkg::MAX_BLOCK_BYTES)) begin
      eff_len = LW'(pdpc_pkg::MAX_BLOCK_BYTES);
    end else begin
      eff_len = LW'(blen_q);
    end
    kind_ok   = pdpc_pkg::kind_valid(kind_q);
    dig_len   = LW'(pdpc_pkg::digest_len(kind_q));
    pref_len  = LW'(pdpc_pkg::prefix_len(kind_q)) + dig_len;
    min_len   = pref_len + LW'(pdpc_pkg::FRAME_BYTES);
    info_base = eff_len - pref_len;
    zero_pos  = info_base - LW'(1);
    dig_base  = eff_len - dig_len;
    last_pos  = eff_len - LW'(1);
  end

  // Expected byte at the current position.
  always_comb begin
    pos_x    = LW'(pos_q);
    info_off = pos_x - info_base;
    dig_off  = pos_x - dig_base;

    stage_d          = '0;
    stage_d.data     = req.data_byte;
    stage_d.load     = (req.cmd == pdpc_pkg::CMD_LOAD);
    stage_d.kind_ok  = kind_ok;
    stage_d.len_err  = kind_ok && (eff_len < min_len);
    stage_d.cmp_en   = kind_ok && !stage_d.len_err && (pos_x < eff_len) && !stage_d.load;
    stage_d.last     = !stage_d.load && (pos_x >= last_pos);
    stage_d.exp_byte = pdpc_pkg::MARK_ZERO;
    stage_d.use_dig  = 1'b0;
    priority if (pos_x == '0) begin
      stage_d.exp_byte = pdpc_pkg::MARK_START;
    end else if (pos_x < zero_pos) begin
      stage_d.exp_byte = pdpc_pkg::PAD_BYTE;
    end else if (pos_x == zero_pos) begin
      stage_d.exp_byte = pdpc_pkg::MARK_ZERO;
    end else if (pos_x < dig_base) begin
      stage_d.exp_byte = pdpc_pkg::info_byte(kind_q, info_off[4:0]);
    end else begin
      stage_d.use_dig = 1'b1;
    end
  end

  // Store access: loads write, checked bytes read at their digest offset.
  always_comb begin
    mem_req_o.wr    = accept && (req.cmd == pdpc_pkg::CMD_LOAD);
    mem_req_o.rd    = accept && (req.cmd == pdpc_pkg::CMD_CHECK);
    mem_req_o.wdata = req.data_byte;
    if (req.cmd == pdpc_pkg::CMD_LOAD) begin
      mem_req_o.addr = req.digest_index[pdpc_pkg::DIG_AW-1:0];
    end else begin
      mem_req_o.addr = dig_off[pdpc_pkg::DIG_AW-1:0];
    end
  end

  // Next position: a load or the final byte restarts the block.
  always_comb begin
    if (stage_d.load || stage_d.last) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + pdpc_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
      end
      if (accept) begin
        vld_q <= 1'b1;
      end else if (adv_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o     = stage_q;
  assign stage_vld_o = vld_q;

endmodule

### rtl/pdpc_verdict.sv
// Byte compare, sticky mismatch flag and the verdict output register.
// Depends on pdpc_pkg and on the verdict channel in pdpc_if.

module pdpc_verdict (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pdpc_pkg::chk_t              stage_i,
  input  logic                        stage_vld_i,
  input  logic [pdpc_pkg::BYTE_W-1:0] dig_byte_i,
  output logic                        adv_o,
  pdpc_rsp_if.source                  rsp
);

  logic                        mis_q;
  logic                        out_vld_q;
  logic                        ok_q, len_err_q;
  logic                        mis_now;
  logic                        out_free;
  logic [pdpc_pkg::BYTE_W-1:0] ref_byte;

  assign out_free = !out_vld_q || rsp.ready;
  // Only a final byte needs room in the output register.
  assign adv_o    = stage_vld_i && (!stage_i.last || out_free);

  assign ref_byte = stage_i.use_dig ? dig_byte_i : stage_i.exp_byte;
  assign mis_now  = stage_i.cmp_en && (stage_i.data != ref_byte);

  // Sticky mismatch; cleared by a load and after each verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mis_q <= 1'b0;
    end else if (adv_o) begin
      if (stage_i.load || stage_i.last) begin
        mis_q <= 1'b0;
      end else begin
        mis_q <= mis_q || mis_now;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_o && stage_i.last) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Verdict payload.
  always_ff @(posedge clk_i) begin
    if (adv_o && stage_i.last) begin
      ok_q      <= stage_i.kind_ok && !stage_i.len_err && !(mis_q || mis_now);
      len_err_q <= stage_i.len_err;
    end
  end

  assign rsp.valid        = out_vld_q;
  assign rsp.block_ok     = ok_q;
  assign rsp.length_error = len_err_q;

endmodule

### rtl/pkcs1_v15_digest_pad_check_top.sv
// Top level of the PKCS #1 v1.5 digest padding checker.
// Depends on pdpc_pkg, pdpc_if, pdpc_digest_store, pdpc_seq and pdpc_verdict.
//
//   Channel   Direction  Payload                              Moves
//   req_i     in         cmd, digest_index, data_byte         one request per byte
//   rsp_o     out        block_ok, length_error               one verdict per block
//   cfg_*     in         cfg_index_i, cfg_wdata_i (write)     digest_kind, block_length
//
// One request is taken every cycle unless a waiting verdict stalls the input stage; each passes
// the input stage and the compare stage, which registers the verdict of a block's final byte.
// The digest store read is registered together with the input stage.
// Reset clears the position counter, the mismatch flag and all valid bits and restores
// digest_kind to SHA-256 and block_length to 256; the digest store keeps no reset.
// A verdict waiting in the output register stalls requests only when the next one
// to reach the compare stage is itself a final byte.

module pkcs1_v15_digest_pad_check_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pdpc_req_if.sink                       req_i,
  pdpc_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [pdpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdpc_pkg::BLKLEN_W-1:0]  cfg_wdata_i
);

  pdpc_pkg::chk_t              stage;
  logic                        stage_vld;
  logic                        adv;
  pdpc_pkg::mem_req_t          mem_req;
  logic [pdpc_pkg::BYTE_W-1:0] dig_byte;

  // Layout decode and input stage.
  pdpc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .stage_o     (stage),
    .stage_vld_o (stage_vld),
    .mem_req_o   (mem_req)
  );

  // Expected digest bytes.
  pdpc_digest_store u_store (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rdata_o   (dig_byte)
  );

  // Compare and verdict.
  pdpc_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .stage_vld_i (stage_vld),
    .dig_byte_i  (dig_byte),
    .adv_o       (adv),
    .rsp         (rsp_o)
  );

endmodule
